[hw/rtl/swrl_pkg.sv]
// Package for the sliding window rate limiter.
// Widths, journal depth, register codes, reset values and shared types.
// No dependencies.
package swrl_pkg;

  localparam int JOURNAL_DEPTH = 64;
  localparam int IDX_W         = $clog2(JOURNAL_DEPTH);
  localparam int CNT_W         = $clog2(JOURNAL_DEPTH + 1);

  localparam int WEIGHT_W   = 32;
  localparam int TIME_W     = 48;
  localparam int REQ_W      = 7;
  localparam int WAIT_W     = 32;
  localparam int HELD_W     = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = WEIGHT_W + IDX_W;
  localparam int ENTRY_W    = WEIGHT_W + TIME_W;
  localparam int LIM_W      = ((REQ_W > CNT_W) ? REQ_W : CNT_W) + 1;

  localparam logic [TIME_W:0] ONE_SECOND_US = (TIME_W + 1)'(1000000);

  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT_RST   = WEIGHT_W'(1000);
  localparam logic [REQ_W-1:0]    MAX_REQUESTS_RST = REQ_W'(64);
  localparam logic [WAIT_W-1:0]   MAX_WAIT_RST     = WAIT_W'(1000000);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_WEIGHT   = 2'd0,
    CFG_MAX_REQUESTS = 2'd1,
    CFG_MAX_WAIT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] max_weight;
    logic [REQ_W-1:0]    max_requests;
    logic [WAIT_W-1:0]   max_wait_us;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EVAL   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

endpackage

[hw/rtl/swrl_if.sv]
// Request and response channel interfaces for the rate limiter.
// Depends on swrl_pkg.
interface swrl_req_if;
  import swrl_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [TIME_W-1:0]   now_us;
  modport source (output valid, weight, now_us, input ready);
  modport sink   (input valid, weight, now_us, output ready);
endinterface

interface swrl_rsp_if;
  import swrl_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [TIME_W-1:0] start_us;
  logic [HELD_W-1:0] entries_held;
  modport source (output valid, accepted, start_us, entries_held, input ready);
  modport sink   (input valid, accepted, start_us, entries_held, output ready);
endinterface

[hw/rtl/swrl_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module swrl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/swrl_cfg.sv]
// Configuration registers of the rate limiter.
// Depends on swrl_pkg.
module swrl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swrl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output swrl_pkg::cfg_t                      cfg_o
);
  import swrl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MAX_WEIGHT:   cfg_nxt.max_weight   = cfg_wdata[WEIGHT_W-1:0];
        CFG_MAX_REQUESTS: cfg_nxt.max_requests = cfg_wdata[REQ_W-1:0];
        CFG_MAX_WAIT:     cfg_nxt.max_wait_us  = cfg_wdata[WAIT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_weight   <= MAX_WEIGHT_RST;
      cfg_r.max_requests <= MAX_REQUESTS_RST;
      cfg_r.max_wait_us  <= MAX_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

[hw/rtl/swrl_ctrl.sv]
// Sequencer and datapath: retire walk over the journal RAM, wait test, commit.
// Depends on swrl_pkg and swrl_if.
module swrl_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swrl_pkg::cfg_t                 cfg_i,
  swrl_req_if.sink                       in_ch,
  swrl_rsp_if.source                     out_ch,
  output swrl_pkg::mem_req_t             mem_req,
  input  logic [swrl_pkg::ENTRY_W-1:0]   mem_rdata
);
  import swrl_pkg::*;

  state_t              state_r, state_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [SUM_W-1:0]    weight_sum_r, weight_sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic [TIME_W-1:0]   out_start_r, out_start_nxt;
  logic [HELD_W-1:0]   out_held_r, out_held_nxt;

  logic [WEIGHT_W-1:0] ent_w;
  logic [TIME_W-1:0]   ent_t;
  logic [LIM_W-1:0]    req_ext, limit, cnt_plus;
  logic [SUM_W:0]      sum_plus_w;
  logic                retire;
  logic [TIME_W:0]     t_raw;
  logic [TIME_W-1:0]   t_sat;
  logic [TIME_W-1:0]   wait_us;
  logic                reject;
  logic [IDX_W:0]      slot_raw;
  logic [IDX_W-1:0]    slot;
  logic                out_free;

  assign ent_w = mem_rdata[ENTRY_W-1:TIME_W];
  assign ent_t = mem_rdata[TIME_W-1:0];

  assign req_ext  = LIM_W'(cfg_i.max_requests);
  assign limit    = (req_ext > LIM_W'(JOURNAL_DEPTH)) ? LIM_W'(JOURNAL_DEPTH) : req_ext;
  assign cnt_plus = LIM_W'(cnt_r) + LIM_W'(1);

  assign sum_plus_w = {1'b0, sum_r} + (SUM_W + 1)'(w_r);
  assign retire     = (cnt_r != '0) &&
                      ((sum_plus_w > (SUM_W + 1)'(cfg_i.max_weight)) || (cnt_plus > limit));

  assign t_raw = {1'b0, ent_t} + ONE_SECOND_US;
  assign t_sat = t_raw[TIME_W] ? '1 : t_raw[TIME_W-1:0];

  assign wait_us = start_r - now_r;
  assign reject  = wait_us > TIME_W'(cfg_i.max_wait_us);

  assign slot_raw = {1'b0, head_r} + (IDX_W + 1)'(cnt_r);
  assign slot     = (slot_raw >= (IDX_W + 1)'(JOURNAL_DEPTH)) ?
                    IDX_W'(slot_raw - (IDX_W + 1)'(JOURNAL_DEPTH)) : slot_raw[IDX_W-1:0];

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    w_nxt           = w_r;
    now_nxt         = now_r;
    start_nxt       = start_r;
    sum_nxt         = sum_r;
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    oldest_nxt      = oldest_r;
    entry_count_nxt = entry_count_r;
    weight_sum_nxt  = weight_sum_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_acc_nxt     = out_acc_r;
    out_start_nxt   = out_start_r;
    out_held_nxt    = out_held_r;
    mem_req.we      = 1'b0;
    mem_req.waddr   = slot;
    mem_req.wdata   = {w_r, start_r};

    unique case (state_r)
      ST_IDLE: begin
        // head read is issued here so the data lands in EVAL
        head_nxt  = oldest_r;
        cnt_nxt   = entry_count_r;
        sum_nxt   = weight_sum_r;
        w_nxt     = in_ch.weight;
        now_nxt   = in_ch.now_us;
        start_nxt = in_ch.now_us;
        if (in_ch.valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (retire) begin
          start_nxt = (t_sat > start_r) ? t_sat : start_r;
          sum_nxt   = sum_r - SUM_W'(ent_w);
          head_nxt  = (head_r == IDX_W'(JOURNAL_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
          cnt_nxt   = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (reject) begin
            out_acc_nxt   = 1'b0;
            out_start_nxt = '0;
            out_held_nxt  = HELD_W'(entry_count_r);
          end else begin
            mem_req.we      = 1'b1;
            oldest_nxt      = head_r;
            entry_count_nxt = cnt_r + CNT_W'(1);
            weight_sum_nxt  = sum_r + SUM_W'(w_r);
            out_acc_nxt     = 1'b1;
            out_start_nxt   = start_r;
            out_held_nxt    = HELD_W'(cnt_r + CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    mem_req.raddr = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      oldest_r      <= '0;
      entry_count_r <= '0;
      weight_sum_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      oldest_r      <= oldest_nxt;
      entry_count_r <= entry_count_nxt;
      weight_sum_r  <= weight_sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    now_r       <= now_nxt;
    start_r     <= start_nxt;
    sum_r       <= sum_nxt;
    head_r      <= head_nxt;
    cnt_r       <= cnt_nxt;
    out_acc_r   <= out_acc_nxt;
    out_start_r <= out_start_nxt;
    out_held_r  <= out_held_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.start_us     = out_start_r;
  assign out_ch.entries_held = out_held_r;

endmodule

[hw/rtl/sliding_window_rate_limiter_top.sv]
// Top level of the sliding window rate limiter.
// Depends on swrl_pkg, swrl_if, swrl_cfg, swrl_ctrl and swrl_ram.
//
//   port     dir  handshake       payload
//   in_ch    in   valid/ready     weight[31:0], now_us[47:0]
//   out_ch   out  valid/ready     accepted, start_us[47:0], entries_held[6:0]
//   cfg_*    in   cfg_we          cfg_addr[1:0], cfg_wdata[31:0]
//
// A transaction makes one journal RAM read per retired entry, with read-ahead of the next,
// and retires at most JOURNAL_DEPTH entries.
// Reset is synchronous; the journal RAM needs no clearing pass.
// in_ch.ready is high in idle, also while a result waits on out_ch; a stalled
// out_ch holds the next result in the commit step.
module sliding_window_rate_limiter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swrl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  swrl_req_if.sink                        in_ch,
  swrl_rsp_if.source                      out_ch
);
  import swrl_pkg::*;

  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  swrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  swrl_ram #(
    .DEPTH (JOURNAL_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_rate_limiter_top: directed and random
// requests against an in-bench journal predictor. Needs swrl_pkg, swrl_if and the RTL.
module tb;
  import swrl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [TIME_W-1:0]   now_us;
  } request_t;

  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] start_us;
    logic [HELD_W-1:0] entries_held;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  swrl_req_if req_ch ();
  swrl_rsp_if rsp_ch ();

  sliding_window_rate_limiter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [WEIGHT_W-1:0] jrnl_weight [JOURNAL_DEPTH];
  logic [TIME_W-1:0]   jrnl_time [JOURNAL_DEPTH];
  int unsigned         jrnl_head;
  int unsigned         jrnl_count;
  logic [SUM_W-1:0]    jrnl_sum;
  logic [WEIGHT_W-1:0] lim_weight;
  logic [REQ_W-1:0]    lim_reqs;
  logic [WAIT_W-1:0]   lim_wait;

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  request_t next_req;
  verdict_t want, got;

  logic        steady = 1'b0;
  logic [63:0] wall_us;
  int unsigned sent_count, result_count, granted_count, mismatch_count;

  function automatic verdict_t admit_request(logic [WEIGHT_W-1:0] w, logic [TIME_W-1:0] now);
    verdict_t    v;
    logic [63:0] start, t, s;
    int unsigned cap, h, n, slot;
    start = now;
    cap = (lim_reqs > JOURNAL_DEPTH) ? JOURNAL_DEPTH : lim_reqs;
    h = jrnl_head;
    n = jrnl_count;
    s = jrnl_sum;
    while (n > 0 && ((s + w) > {32'd0, lim_weight} || n + 1 > cap)) begin
      t = {16'd0, jrnl_time[h]} + ONE_SECOND_US;
      if (t > TIME_MAX) t = TIME_MAX;
      if (t > start) start = t;
      s = s - jrnl_weight[h];
      h = (h == JOURNAL_DEPTH - 1) ? 0 : h + 1;
      n--;
    end
    if (start - {16'd0, now} > {32'd0, lim_wait}) begin
      v.accepted = 1'b0;
      v.start_us = '0;
      v.entries_held = HELD_W'(jrnl_count);
      return v;
    end
    slot = (h + n) % JOURNAL_DEPTH;
    jrnl_weight[slot] = w;
    jrnl_time[slot] = start[TIME_W-1:0];
    jrnl_head = h;
    jrnl_count = n + 1;
    jrnl_sum = SUM_W'(s + w);
    v.accepted = 1'b1;
    v.start_us = start[TIME_W-1:0];
    v.entries_held = HELD_W'(jrnl_count);
    return v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 45) return $urandom_range(255);
    if (r < 75) return $urandom_range(lim_weight >> 2);
    if (r < 85) return (lim_weight == '1 || r[0]) ? lim_weight : lim_weight + 1;
    if (r < 95) return $urandom;
    return '1;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time(int unsigned pace);
    int unsigned r;
    logic [63:0] back;
    r = $urandom_range(99);
    if (r >= 92 && r < 97) begin
      back = $urandom_range(2_000_000);
      return (wall_us > back) ? TIME_W'(wall_us - back) : '0;
    end
    if (r < 10)      wall_us = wall_us;
    else if (r < 65) wall_us = wall_us + $urandom_range(pace);
    else if (r < 85) wall_us = wall_us + $urandom_range(1_500_000);
    else if (r < 92) wall_us = wall_us + $urandom_range(5_000_000);
    else             wall_us = wall_us + $urandom;
    if (wall_us > TIME_MAX) wall_us = TIME_MAX;
    return TIME_W'(wall_us);
  endfunction

  task automatic push_req(input logic [WEIGHT_W-1:0] w, input logic [TIME_W-1:0] now);
    request_t rq;
    rq.weight = w;
    rq.now_us = now;
    pending_requests.push_back(rq);
    sent_count++;
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned pace);
    logic [WEIGHT_W-1:0] w;
    repeat (n) begin
      w = pick_weight();
      push_req(w, pick_time(pace));
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAX_WEIGHT:   lim_weight = val[WEIGHT_W-1:0];
      CFG_MAX_REQUESTS: lim_reqs = val[REQ_W-1:0];
      CFG_MAX_WAIT:     lim_wait = val[WAIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] mw, input logic [31:0] mr, input logic [31:0] mwait);
    write_reg(CFG_MAX_WEIGHT, mw);
    write_reg(CFG_MAX_REQUESTS, mr);
    write_reg(CFG_MAX_WAIT, mwait);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] mw, input logic [31:0] mr, input logic [31:0] mwait,
                           input int unsigned n, input int unsigned pace, input logic quiet);
    configure(mw, mr, mwait);
    steady = quiet;
    queue_random(n, pace);
    settle();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) expected_verdicts.push_back(admit_request(req_ch.weight, req_ch.now_us));
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
        next_req = pending_requests[0];
        pending_requests.delete(0);
        req_ch.valid <= 1'b1;
        req_ch.weight <= next_req.weight;
        req_ch.now_us <= next_req.now_us;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 9);
      if (rsp_ch.valid && rsp_ch.ready) begin
        result_count++;
        got.accepted = rsp_ch.accepted;
        got.start_us = rsp_ch.start_us;
        got.entries_held = rsp_ch.entries_held;
        if (got.accepted) granted_count++;
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no transaction outstanding: accepted %0b start_us %0h held %0d",
                     $time, got.accepted, got.start_us, got.entries_held);
        end else begin
          want = expected_verdicts[0];
          expected_verdicts.delete(0);
          if (got.accepted !== want.accepted || got.start_us !== want.start_us ||
              got.entries_held !== want.entries_held) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch (exp/act) accepted %0b/%0b start_us %0h/%0h held %0d/%0d",
                       $time, want.accepted, got.accepted, want.start_us, got.start_us,
                       want.entries_held, got.entries_held);
          end
        end
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.weight = '0;
    req_ch.now_us = '0;
    rsp_ch.ready = 1'b0;
    jrnl_head = 0;
    jrnl_count = 0;
    jrnl_sum = '0;
    lim_weight = MAX_WEIGHT_RST;
    lim_reqs = MAX_REQUESTS_RST;
    lim_wait = MAX_WAIT_RST;
    wall_us = '0;
    sent_count = 0;
    result_count = 0;
    granted_count = 0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits: weight retire, oversize weight, reject, time going back
    push_req(32'd0, 48'd0);
    push_req(32'd1000, 48'd0);
    push_req(32'd1, 48'd10);
    push_req(32'hFFFF_FFFF, 48'd20);
    push_req(32'd5, 48'd2_000_000);
    push_req(32'hFFFF_FFFF, 48'd5_000_000);
    push_req(32'd0, 48'd5_000_001);
    push_req(32'd0, 48'd100);
    settle();

    // zero request limit, spare register index
    configure(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_req(32'd1, 48'd10_000_000);
    push_req(32'd2, 48'd10_000_000);
    push_req(32'd3, 48'd10_000_001);
    settle();

    // zero wait, limit above depth
    configure(32'd2000, 32'd127, 32'd0);
    push_req(32'd2000, 48'd20_000_000);
    push_req(32'd0, 48'd30_000_000);
    push_req(32'd1999, 48'd30_000_000);
    settle();

    wall_us = 64'd40_000_000;
    run_phase(MAX_WEIGHT_RST, MAX_REQUESTS_RST, MAX_WAIT_RST, 250, 50_000, 1'b0);
    run_phase(32'd0, 32'd1, 32'd0, 150, 50_000, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd127, 32'hFFFF_FFFF, 250, 2_000, 1'b1);
    run_phase($urandom_range(20_000), $urandom_range(64, 1), $urandom_range(3_000_000),
              300, 50_000, 1'b0);
    run_phase(32'd5000, 32'hFFFF_FF88, 32'd500_000, 200, 50_000, 1'b0);
    run_phase($urandom, 32'd0, 32'd2_000_000, 150, 50_000, 1'b0);

    // top of the time range: saturating start times
    wall_us = TIME_MAX - 64'd400_000_000;
    run_phase(32'd100_000, 32'd64, 32'hFFFF_FFFF, 200, 50_000, 1'b0);
    push_req(32'd0, 48'hFFFF_FFFF_FFFB);
    push_req(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_req(32'd1, 48'hFFFF_FFFF_FFFF);
    settle();

    repeat (80) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", expected_verdicts.size());
    end
    $display("%0d requests over 10 limit settings; %0d results, %0d admitted, %0d rejected",
             sent_count, result_count, granted_count, result_count - granted_count);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d results outstanding", expected_verdicts.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sliding_window_rate_limiter_top.f]
hw/rtl/swrl_pkg.sv
hw/rtl/swrl_if.sv
hw/rtl/swrl_ram.sv
hw/rtl/swrl_cfg.sv
hw/rtl/swrl_ctrl.sv
hw/rtl/sliding_window_rate_limiter_top.sv
bench/tb.sv
